// ===== sv/tcr_de_pkg.sv =====
`default_nettype none
package tcr_de_pkg;

  localparam int DICT_ENTRIES          = 256;
  localparam int MAX_ENTRY_LEN_DEF     = 255;
  localparam int BYTES_PER_RESULT_DEF  = 8;
  localparam int SIG_LEN               = 9;
  localparam int CHUNK_W               = 64;
  localparam int COUNT_W               = 4;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_DICT   = 2'd1;
  localparam logic [1:0] PH_TEXT   = 2'd2;
  localparam logic [1:0] PH_ERROR  = 2'd3;

  typedef struct packed {
    logic               status;
    logic [COUNT_W-1:0] count;
    logic               last;
  } tag_t;

  typedef struct packed {
    logic               status;
    logic [CHUNK_W-1:0] chunk;
    logic [COUNT_W-1:0] count;
    logic               last;
  } out_item_t;

  function automatic logic [7:0] sig_byte(input logic [3:0] pos);
    logic [7:0] b;
    unique case (pos)
      4'd0:    b = 8'h21;
      4'd1:    b = 8'h21;
      4'd2:    b = 8'h38;
      4'd3:    b = 8'h2D;
      4'd4:    b = 8'h42;
      4'd5:    b = 8'h69;
      4'd6:    b = 8'h74;
      4'd7:    b = 8'h21;
      4'd8:    b = 8'h21;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== sv/tcr_de_dict_mem.sv =====
`default_nettype none
module tcr_de_dict_mem #(
  parameter int BYTES_PER_RESULT = tcr_de_pkg::BYTES_PER_RESULT_DEF,
  parameter int WORD_W           = 5,
  parameter int LANE_W           = 3
) (
  input  wire logic                          clk,
  input  wire logic                          len_wr_en,
  input  wire logic [7:0]                    len_wr_slot,
  input  wire logic [7:0]                    len_wr_data,
  input  wire logic                          len_rd_en,
  input  wire logic [7:0]                    len_rd_slot,
  output      logic [7:0]                    len_rd_data,
  input  wire logic                          txt_wr_en,
  input  wire logic [7:0]                    txt_wr_slot,
  input  wire logic [WORD_W-1:0]             txt_wr_word,
  input  wire logic [LANE_W-1:0]             txt_wr_lane,
  input  wire logic [7:0]                    txt_wr_data,
  input  wire logic                          txt_rd_en,
  input  wire logic [7:0]                    txt_rd_slot,
  input  wire logic [WORD_W-1:0]             txt_rd_word,
  output      logic [BYTES_PER_RESULT*8-1:0] txt_rd_data
);

  localparam int TXT_DEPTH = tcr_de_pkg::DICT_ENTRIES << WORD_W;

  logic [7:0]                    len_mem [tcr_de_pkg::DICT_ENTRIES];
  logic [BYTES_PER_RESULT*8-1:0] txt_mem [TXT_DEPTH];

  always_ff @(posedge clk) begin
    if (len_wr_en) begin
      len_mem[len_wr_slot] <= len_wr_data;
    end
    if (len_rd_en) begin
      len_rd_data <= len_mem[len_rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (txt_wr_en) begin
      txt_mem[{txt_wr_slot, txt_wr_word}][txt_wr_lane*8 +: 8] <= txt_wr_data;
    end
    if (txt_rd_en) begin
      txt_rd_data <= txt_mem[{txt_rd_slot, txt_rd_word}];
    end
  end

endmodule
`default_nettype wire

// ===== sv/tcr_de_out_fifo.sv =====
`default_nettype none
module tcr_de_out_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire tcr_de_pkg::out_item_t push_item,
  input  wire logic                  pop,
  output      logic                  out_valid,
  output      tcr_de_pkg::out_item_t out_item,
  output      logic [1:0]            fill
);

  tcr_de_pkg::out_item_t slots [2];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic                  do_pop;

  assign out_valid = (fill != 2'd0);
  assign out_item  = slots[rd_ptr];
  assign do_pop    = pop && out_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/tcr_de_ctrl.sv =====
`default_nettype none
module tcr_de_ctrl #(
  parameter int MAX_ENTRY_LEN    = tcr_de_pkg::MAX_ENTRY_LEN_DEF,
  parameter int BYTES_PER_RESULT = tcr_de_pkg::BYTES_PER_RESULT_DEF,
  parameter int WORD_W           = 5,
  parameter int LANE_W           = 3
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire logic              in_action,
  input  wire logic [7:0]        in_byte,
  input  wire logic              space,
  output      logic              len_wr_en,
  output      logic [7:0]        len_wr_data,
  output      logic [7:0]        wr_slot,
  output      logic              len_rd_en,
  output      logic [7:0]        len_rd_slot,
  input  wire logic [7:0]        len_rd_data,
  output      logic              txt_wr_en,
  output      logic [WORD_W-1:0] txt_wr_word,
  output      logic [LANE_W-1:0] txt_wr_lane,
  output      logic              txt_rd_en,
  output      logic [7:0]        txt_rd_slot,
  output      logic [WORD_W-1:0] txt_rd_word,
  output      logic              rsp_valid,
  output      tcr_de_pkg::tag_t  rsp_tag
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LEN  = 2'd1;
  localparam logic [1:0] ST_EXP  = 2'd2;

  localparam logic [7:0]  MAX_LEN_8  = 8'(MAX_ENTRY_LEN);
  localparam logic [7:0]  BPR_8      = 8'(BYTES_PER_RESULT);
  localparam logic [8:0]  LAST_ENTRY = 9'(tcr_de_pkg::DICT_ENTRIES - 1);
  localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(BYTES_PER_RESULT - 1);

  logic [1:0]        state, state_next;
  logic [1:0]        phase, phase_next;
  logic [3:0]        hpos, hpos_next;
  logic [8:0]        entry_number, entry_number_next;
  logic [7:0]        bytes_left, bytes_left_next;
  logic [7:0]        wr_pos, wr_pos_next;
  logic [LANE_W-1:0] wr_lane, wr_lane_next;
  logic [WORD_W-1:0] wr_word, wr_word_next;
  logic [7:0]        exp_slot, exp_slot_next;
  logic [WORD_W-1:0] exp_word, exp_word_next;
  logic [7:0]        remain, remain_next;
  logic              accept;
  logic              issue;
  tcr_de_pkg::tag_t  issue_tag;

  assign in_ready    = (state == ST_IDLE) && space;
  assign accept      = in_valid && in_ready;
  assign wr_slot     = entry_number[7:0];
  assign txt_wr_word = wr_word;
  assign txt_wr_lane = wr_lane;
  assign len_rd_slot = in_byte;
  assign txt_rd_slot = exp_slot;
  assign txt_rd_word = exp_word;

  always_comb begin
    state_next        = state;
    phase_next        = phase;
    hpos_next         = hpos;
    entry_number_next = entry_number;
    bytes_left_next   = bytes_left;
    wr_pos_next       = wr_pos;
    wr_lane_next      = wr_lane;
    wr_word_next      = wr_word;
    exp_slot_next     = exp_slot;
    exp_word_next     = exp_word;
    remain_next       = remain;
    len_wr_en         = 1'b0;
    len_wr_data       = (in_byte > MAX_LEN_8) ? MAX_LEN_8 : in_byte;
    len_rd_en         = 1'b0;
    txt_wr_en         = 1'b0;
    txt_rd_en         = 1'b0;
    issue             = 1'b0;
    issue_tag         = '{status: 1'b0, count: '0, last: 1'b0};

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_action) begin
            phase_next        = tcr_de_pkg::PH_HEADER;
            hpos_next         = 4'd0;
            entry_number_next = 9'd0;
            bytes_left_next   = 8'd0;
            wr_pos_next       = 8'd0;
          end else begin
            unique case (phase)
              tcr_de_pkg::PH_HEADER: begin
                if ((hpos >= 4'(tcr_de_pkg::SIG_LEN)) ||
                    (in_byte != tcr_de_pkg::sig_byte(hpos))) begin
                  phase_next       = tcr_de_pkg::PH_ERROR;
                  issue            = 1'b1;
                  issue_tag.status = 1'b1;
                end else begin
                  hpos_next = hpos + 4'd1;
                  if (hpos == 4'(tcr_de_pkg::SIG_LEN - 1)) begin
                    phase_next        = tcr_de_pkg::PH_DICT;
                    entry_number_next = 9'd0;
                    bytes_left_next   = 8'd0;
                    wr_pos_next       = 8'd0;
                  end
                end
              end
              tcr_de_pkg::PH_DICT: begin
                if (bytes_left == 8'd0) begin
                  len_wr_en       = 1'b1;
                  bytes_left_next = in_byte;
                  wr_pos_next     = 8'd0;
                  wr_lane_next    = '0;
                  wr_word_next    = '0;
                end else begin
                  txt_wr_en       = (wr_pos < MAX_LEN_8);
                  wr_pos_next     = wr_pos + 8'd1;
                  bytes_left_next = bytes_left - 8'd1;
                  if (wr_lane == LAST_LANE) begin
                    wr_lane_next = '0;
                    wr_word_next = wr_word + WORD_W'(1);
                  end else begin
                    wr_lane_next = wr_lane + LANE_W'(1);
                  end
                end
                if (bytes_left_next == 8'd0) begin
                  entry_number_next = entry_number + 9'd1;
                  bytes_left_next   = 8'd0;
                  wr_pos_next       = 8'd0;
                  if (entry_number == LAST_ENTRY) begin
                    phase_next = tcr_de_pkg::PH_TEXT;
                  end
                end
              end
              tcr_de_pkg::PH_TEXT: begin
                len_rd_en     = 1'b1;
                exp_slot_next = in_byte;
                state_next    = ST_LEN;
              end
              default: begin
              end
            endcase
          end
        end
      end
      ST_LEN: begin
        remain_next   = len_rd_data;
        exp_word_next = '0;
        state_next    = (len_rd_data == 8'd0) ? ST_IDLE : ST_EXP;
      end
      ST_EXP: begin
        if (space) begin
          txt_rd_en       = 1'b1;
          issue           = 1'b1;
          issue_tag.count = (remain >= BPR_8) ? 4'(BYTES_PER_RESULT) : remain[3:0];
          issue_tag.last  = (remain <= BPR_8);
          remain_next     = remain - 8'(issue_tag.count);
          exp_word_next   = exp_word + WORD_W'(1);
          if (issue_tag.last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      phase        <= tcr_de_pkg::PH_HEADER;
      hpos         <= 4'd0;
      entry_number <= 9'd0;
      bytes_left   <= 8'd0;
      wr_pos       <= 8'd0;
      wr_lane      <= '0;
      wr_word      <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      phase        <= phase_next;
      hpos         <= hpos_next;
      entry_number <= entry_number_next;
      bytes_left   <= bytes_left_next;
      wr_pos       <= wr_pos_next;
      wr_lane      <= wr_lane_next;
      wr_word      <= wr_word_next;
      rsp_valid    <= issue;
    end
  end

  always_ff @(posedge clk) begin
    exp_slot <= exp_slot_next;
    exp_word <= exp_word_next;
    remain   <= remain_next;
    rsp_tag  <= issue_tag;
  end

  a_issue_has_space: assert property (@(posedge clk) disable iff (rst)
    issue |-> space)
    else $error("result issued without room downstream");

  a_len_follows_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LEN) |-> $past(len_rd_en))
    else $error("length state entered without a length read");

  a_chunk_count: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_tag.status) |->
      (rsp_tag.count != 4'd0) && (rsp_tag.count <= 4'(BYTES_PER_RESULT)))
    else $error("chunk byte count out of range");

  a_text_after_dict: assert property (@(posedge clk) disable iff (rst)
    (phase == tcr_de_pkg::PH_TEXT) |-> (entry_number == 9'(tcr_de_pkg::DICT_ENTRIES)))
    else $error("text phase before the dictionary is complete");

  a_no_write_in_text: assert property (@(posedge clk) disable iff (rst)
    (txt_rd_en || len_rd_en) |-> !(txt_wr_en || len_wr_en))
    else $error("dictionary write overlaps a read");

endmodule
`default_nettype wire

// ===== sv/tcr_dictionary_expander_top.sv =====
// TCR text expander.
// Input stream: one file byte per transfer, tdata = data_byte, tuser = action
// (1 restarts parsing and discards tdata). The first nine bytes must match the
// signature; a mismatch yields one result with tuser = 1 and zero data, after
// which stream bytes are dropped until a restart. Then 256 dictionary entries
// (length byte plus bytes) load at one byte per cycle into on-chip memory.
// Every later byte is an index; its entry is sent as chunks of up to
// BYTES_PER_RESULT bytes, tlast on the final chunk; an empty entry sends none.
// An index's first chunk passes the length read, a text memory read and the output queue.
// Header and dictionary bytes are taken one per cycle while the output queue
// has room; an index holds the input for one length read plus
// ceil(len / BYTES_PER_RESULT) text memory reads, and each chunk passes from
// the registered memory read into the two-entry output queue.
// A stalled receiver fills the output queue and then holds the input.
// Reset clears the parser; dictionary contents are undefined until loaded.
`default_nettype none
module tcr_dictionary_expander_top #(
  parameter int MAX_ENTRY_LEN    = tcr_de_pkg::MAX_ENTRY_LEN_DEF,
  parameter int BYTES_PER_RESULT = tcr_de_pkg::BYTES_PER_RESULT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte
  input  wire logic        s_axis_tuser,   // action
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [71:0] m_axis_tdata,   // chunk_bytes[63:0], byte_count[67:64], zero
  output      logic        m_axis_tuser,   // status
  output      logic        m_axis_tlast    // last_chunk
);

  localparam int WORDS  = (MAX_ENTRY_LEN + BYTES_PER_RESULT - 1) / BYTES_PER_RESULT;
  localparam int WORD_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int LANE_W = (BYTES_PER_RESULT > 1) ? $clog2(BYTES_PER_RESULT) : 1;
  localparam int DATA_W = BYTES_PER_RESULT * 8;

  logic                  space;
  logic [1:0]            fill;
  logic                  len_wr_en;
  logic [7:0]            len_wr_data;
  logic [7:0]            wr_slot;
  logic                  len_rd_en;
  logic [7:0]            len_rd_slot;
  logic [7:0]            len_rd_data;
  logic                  txt_wr_en;
  logic [WORD_W-1:0]     txt_wr_word;
  logic [LANE_W-1:0]     txt_wr_lane;
  logic                  txt_rd_en;
  logic [7:0]            txt_rd_slot;
  logic [WORD_W-1:0]     txt_rd_word;
  logic [DATA_W-1:0]     txt_rd_data;
  logic                  rsp_valid;
  tcr_de_pkg::tag_t      rsp_tag;
  logic [DATA_W-1:0]     masked;
  tcr_de_pkg::out_item_t push_item;
  tcr_de_pkg::out_item_t head;

  assign space = (fill == 2'd0) || ((fill == 2'd1) && !rsp_valid);

  tcr_de_ctrl #(
    .MAX_ENTRY_LEN    (MAX_ENTRY_LEN),
    .BYTES_PER_RESULT (BYTES_PER_RESULT),
    .WORD_W           (WORD_W),
    .LANE_W           (LANE_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_action   (s_axis_tuser),
    .in_byte     (s_axis_tdata),
    .space       (space),
    .len_wr_en   (len_wr_en),
    .len_wr_data (len_wr_data),
    .wr_slot     (wr_slot),
    .len_rd_en   (len_rd_en),
    .len_rd_slot (len_rd_slot),
    .len_rd_data (len_rd_data),
    .txt_wr_en   (txt_wr_en),
    .txt_wr_word (txt_wr_word),
    .txt_wr_lane (txt_wr_lane),
    .txt_rd_en   (txt_rd_en),
    .txt_rd_slot (txt_rd_slot),
    .txt_rd_word (txt_rd_word),
    .rsp_valid   (rsp_valid),
    .rsp_tag     (rsp_tag)
  );

  tcr_de_dict_mem #(
    .BYTES_PER_RESULT (BYTES_PER_RESULT),
    .WORD_W           (WORD_W),
    .LANE_W           (LANE_W)
  ) u_dict_mem (
    .clk         (clk),
    .len_wr_en   (len_wr_en),
    .len_wr_slot (wr_slot),
    .len_wr_data (len_wr_data),
    .len_rd_en   (len_rd_en),
    .len_rd_slot (len_rd_slot),
    .len_rd_data (len_rd_data),
    .txt_wr_en   (txt_wr_en),
    .txt_wr_slot (wr_slot),
    .txt_wr_word (txt_wr_word),
    .txt_wr_lane (txt_wr_lane),
    .txt_wr_data (s_axis_tdata),
    .txt_rd_en   (txt_rd_en),
    .txt_rd_slot (txt_rd_slot),
    .txt_rd_word (txt_rd_word),
    .txt_rd_data (txt_rd_data)
  );

  always_comb begin
    for (int i = 0; i < BYTES_PER_RESULT; i++) begin
      masked[i*8 +: 8] = (i < int'(rsp_tag.count)) ? txt_rd_data[i*8 +: 8] : 8'h00;
    end
  end

  assign push_item.status = rsp_tag.status;
  assign push_item.chunk  = tcr_de_pkg::CHUNK_W'(masked);
  assign push_item.count  = rsp_tag.count;
  assign push_item.last   = rsp_tag.last;

  tcr_de_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (rsp_valid),
    .push_item (push_item),
    .pop       (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_item  (head),
    .fill      (fill)
  );

  assign m_axis_tdata = {4'h0, head.count, head.chunk};
  assign m_axis_tuser = head.status;
  assign m_axis_tlast = head.last;

endmodule
`default_nettype wire
